>>> hdl/preemptive_coprocessor_task_scheduler_assert.svh
// Assertion macros for the task scheduler.
// PCTS_ASSERT_IMP: antecedent implies consequent in the same cycle.
// PCTS_ASSERT_NEXT: antecedent implies consequent in the next cycle.
`ifndef PREEMPTIVE_COPROCESSOR_TASK_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_COPROCESSOR_TASK_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define PCTS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");
`define PCTS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");
`else
`define PCTS_ASSERT_IMP(lbl, ante, cons)
`define PCTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/pcts_pkg.sv
package pcts_pkg;

   // event codes
   localparam logic [1:0] OP_GFX_SUBMIT   = 2'd0;
   localparam logic [1:0] OP_AUDIO_SUBMIT = 2'd1;
   localparam logic [1:0] OP_TASK_DONE    = 2'd2;

   // action codes
   localparam logic [1:0] ACT_START      = 2'd0;
   localparam logic [1:0] ACT_YIELD      = 2'd1;
   localparam logic [1:0] ACT_AUDIO_DONE = 2'd2;
   localparam logic [1:0] ACT_GFX_DONE   = 2'd3;

   localparam int OP_BITS     = 2;
   localparam int GRACE_BITS  = 5;
   localparam int ACT_BITS    = 2;
   localparam int MAX_ACTIONS = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [GRACE_BITS-1:0] AUDIO_MIN_GRACE = 5'd5;

   typedef logic [ACT_BITS-1:0] action_type;

   typedef struct packed {
      logic graphics_running;
      logic audio_running;
      logic graphics_deferred;
      logic yield_requested;
      logic graphics_resume;
   } sched_flags_type;

endpackage

>>> hdl/pcts_decode.sv
module pcts_decode #(
   parameter int TASK_ID_BITS = 8
) (
   input  pcts_pkg::sched_flags_type      flags,
   input  logic [TASK_ID_BITS-1:0]        gfx_handle,
   input  logic [TASK_ID_BITS-1:0]        aud_handle,
   input  logic [pcts_pkg::OP_BITS-1:0]   operation,
   input  logic [TASK_ID_BITS-1:0]        task_id,
   input  logic                           shutdown,
   input  logic [pcts_pkg::GRACE_BITS-1:0] grace_count,
   input  logic                           was_yielded,
   output pcts_pkg::sched_flags_type      flags_next,
   output logic [TASK_ID_BITS-1:0]        gfx_handle_next,
   output logic [TASK_ID_BITS-1:0]        aud_handle_next,
   output logic [1:0]                     act_count,
   output pcts_pkg::action_type           act_code [pcts_pkg::MAX_ACTIONS],
   output logic [TASK_ID_BITS-1:0]        act_task [pcts_pkg::MAX_ACTIONS]
);

   always_comb begin
      flags_next      = flags;
      gfx_handle_next = gfx_handle;
      aud_handle_next = aud_handle;
      act_count       = 2'd0;
      act_code        = '{default: pcts_pkg::ACT_START};
      act_task        = '{default: '0};
      unique case (operation)
         pcts_pkg::OP_GFX_SUBMIT: begin
            if (!shutdown) begin
               gfx_handle_next = task_id;
               if (flags.audio_running) begin
                  flags_next.graphics_deferred = 1'b1;
               end else begin
                  flags_next.graphics_running = 1'b1;
                  act_code[0] = pcts_pkg::ACT_START;
                  act_task[0] = task_id;
                  act_count   = 2'd1;
               end
            end
         end
         pcts_pkg::OP_AUDIO_SUBMIT: begin
            if (grace_count >= pcts_pkg::AUDIO_MIN_GRACE) begin
               aud_handle_next = task_id;
               if (flags.graphics_running) begin
                  flags_next.yield_requested = 1'b1;
                  act_code[0] = pcts_pkg::ACT_YIELD;
               end else begin
                  flags_next.audio_running = 1'b1;
                  act_code[0] = pcts_pkg::ACT_START;
                  act_task[0] = task_id;
               end
               act_count = 2'd1;
            end
         end
         pcts_pkg::OP_TASK_DONE: begin
            if (flags.audio_running) begin
               flags_next.audio_running = 1'b0;
               // deferred start first, then resume, then audio done
               if (flags.graphics_deferred) begin
                  flags_next.graphics_deferred = 1'b0;
                  if (!shutdown) begin
                     flags_next.graphics_running = 1'b1;
                     act_code[act_count] = pcts_pkg::ACT_START;
                     act_task[act_count] = gfx_handle;
                     act_count           = act_count + 2'd1;
                  end
               end
               if (flags.graphics_resume) begin
                  flags_next.graphics_resume  = 1'b0;
                  flags_next.graphics_running = 1'b1;
                  act_code[act_count] = pcts_pkg::ACT_START;
                  act_task[act_count] = gfx_handle;
                  act_count           = act_count + 2'd1;
               end
               act_code[act_count] = pcts_pkg::ACT_AUDIO_DONE;
               act_count           = act_count + 2'd1;
            end else if (flags.graphics_running) begin
               flags_next.graphics_running = 1'b0;
               if (flags.yield_requested) begin
                  flags_next.yield_requested = 1'b0;
                  flags_next.audio_running   = 1'b1;
                  act_code[0] = pcts_pkg::ACT_START;
                  act_task[0] = aud_handle;
                  act_count   = 2'd1;
                  if (was_yielded) begin
                     flags_next.graphics_resume = 1'b1;
                  end
               end
               if (!(flags.yield_requested && was_yielded)) begin
                  act_code[act_count] = pcts_pkg::ACT_GFX_DONE;
                  act_count           = act_count + 2'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

>>> hdl/preemptive_coprocessor_task_scheduler.sv
// Channel  Dir  Handshake      Payload
// req      in   tvalid/tready  req_tdata: operation, task_id, shutdown, grace_count, was_yielded
// rsp      out  tvalid/tready  rsp_tdata: action, action_task; rsp_tlast: last
//
// An event is taken on a req handshake; its state update and its zero to three actions are
// settled by one pass of decode logic, and events with actions enter an event queue two
// entries deep. Actions leave one per beat; the first, if the queue was empty, appears the
// cycle after the event is taken. An event with k actions holds the result port for k beats,
// so while rsp_tready stays high the sustained rate is one event per cycle for single-action events.
// req_tready drops only while both queue entries are occupied.
// Synchronous active-high reset clears the scheduler flags and empties the queue.
module preemptive_coprocessor_task_scheduler #(
   parameter int TASK_ID_BITS = 8,
   localparam int REQ_RAW  = pcts_pkg::OP_BITS + TASK_ID_BITS + 1 + pcts_pkg::GRACE_BITS + 1,
   localparam int REQ_BITS = ((REQ_RAW + 7) / 8) * 8,
   localparam int RSP_RAW  = pcts_pkg::ACT_BITS + TASK_ID_BITS,
   localparam int RSP_BITS = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [1:0] operation, [TASK_ID_BITS+1:2] task_id, then shutdown, grace_count,
   // was_yielded, zero padding to whole bytes
   input  logic [REQ_BITS-1:0]  req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [1:0] action, [TASK_ID_BITS+1:2] action_task, zero padding to whole bytes
   output logic [RSP_BITS-1:0]  rsp_tdata,
   output logic                 rsp_tlast
);

   localparam int TASK_LO  = pcts_pkg::OP_BITS;
   localparam int SHUT_POS = TASK_LO + TASK_ID_BITS;
   localparam int GRACE_LO = SHUT_POS + 1;
   localparam int YLD_POS  = GRACE_LO + pcts_pkg::GRACE_BITS;

   // unpack the request beat
   logic [pcts_pkg::OP_BITS-1:0]    req_operation;
   logic [TASK_ID_BITS-1:0]         req_task_id;
   logic                            req_shutdown;
   logic [pcts_pkg::GRACE_BITS-1:0] req_grace_count;
   logic                            req_was_yielded;

   assign req_operation   = req_tdata[pcts_pkg::OP_BITS-1:0];
   assign req_task_id     = req_tdata[SHUT_POS-1:TASK_LO];
   assign req_shutdown    = req_tdata[SHUT_POS];
   assign req_grace_count = req_tdata[YLD_POS-1:GRACE_LO];
   assign req_was_yielded = req_tdata[YLD_POS];

   // scheduler state
   pcts_pkg::sched_flags_type flags_ff, flags_in;
   logic [TASK_ID_BITS-1:0]   gfx_handle_ff, gfx_handle_in;
   logic [TASK_ID_BITS-1:0]   aud_handle_ff, aud_handle_in;

   logic [1:0]                dec_count;
   pcts_pkg::action_type      dec_code [pcts_pkg::MAX_ACTIONS];
   logic [TASK_ID_BITS-1:0]   dec_task [pcts_pkg::MAX_ACTIONS];

   pcts_decode #(
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_decode (
      .flags           (flags_ff),
      .gfx_handle      (gfx_handle_ff),
      .aud_handle      (aud_handle_ff),
      .operation       (req_operation),
      .task_id         (req_task_id),
      .shutdown        (req_shutdown),
      .grace_count     (req_grace_count),
      .was_yielded     (req_was_yielded),
      .flags_next      (flags_in),
      .gfx_handle_next (gfx_handle_in),
      .aud_handle_next (aud_handle_in),
      .act_count       (dec_count),
      .act_code        (dec_code),
      .act_task        (dec_task)
   );

   // event queue: each entry holds one event's whole action list
   pcts_pkg::action_type    q_code_ff  [pcts_pkg::QUEUE_DEPTH][pcts_pkg::MAX_ACTIONS];
   logic [TASK_ID_BITS-1:0] q_task_ff  [pcts_pkg::QUEUE_DEPTH][pcts_pkg::MAX_ACTIONS];
   logic [1:0]              q_count_ff [pcts_pkg::QUEUE_DEPTH];

   logic       head_ff, head_in;
   logic       tail_ff, tail_in;
   logic [1:0] fill_ff, fill_in;
   logic [1:0] beat_ff, beat_in;

   logic req_fire, push, rsp_fire, rsp_last, pop;
   logic gfx_pending;

   assign req_tready = (fill_ff != 2'd2);
   assign req_fire   = req_tvalid && req_tready;
   // events that emit nothing never enter the queue
   assign push       = req_fire && (dec_count != 2'd0);

   assign rsp_tvalid = (fill_ff != 2'd0);
   assign rsp_last   = (beat_ff == (q_count_ff[head_ff] - 2'd1));
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign pop        = rsp_fire && rsp_last;

   assign rsp_tdata  = RSP_BITS'({q_task_ff[head_ff][beat_ff], q_code_ff[head_ff][beat_ff]});
   assign rsp_tlast  = rsp_last;

   assign gfx_pending = flags_ff.graphics_deferred || flags_ff.graphics_resume;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      beat_in = beat_ff;
      // advance within the head event, drop it after its last beat
      if (rsp_fire) begin
         if (rsp_last) begin
            beat_in = 2'd0;
            head_in = ~head_ff;
         end else begin
            beat_in = beat_ff + 2'd1;
         end
      end
      if (push) begin
         tail_in = ~tail_ff;
      end
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         fill_ff  <= 2'd0;
         beat_ff  <= 2'd0;
      end else begin
         if (req_fire) begin
            flags_ff <= flags_in;
         end
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         beat_ff <= beat_in;
      end
   end

   // payload: handles and queue contents carry no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         gfx_handle_ff <= gfx_handle_in;
         aud_handle_ff <= aud_handle_in;
      end
      if (push) begin
         q_count_ff[tail_ff] <= dec_count;
         q_code_ff[tail_ff]  <= dec_code;
         q_task_ff[tail_ff]  <= dec_task;
      end
   end

`include "preemptive_coprocessor_task_scheduler_assert.svh"

   // the coprocessor never runs both classes at once
`PCTS_ASSERT_IMP(a_one_class, 1'b1, !(flags_ff.graphics_running && flags_ff.audio_running))
   // deferred or resumed graphics only exists under a running audio task
`PCTS_ASSERT_IMP(a_pending_under_audio, gfx_pending, flags_ff.audio_running)
   // beat index stays inside the head event's action list
`PCTS_ASSERT_IMP(a_beat_in_event, rsp_tvalid, beat_ff < q_count_ff[head_ff])
   // after a push the result port is valid in the next cycle
`PCTS_ASSERT_NEXT(a_push_visible, push, rsp_tvalid)

endmodule
